// ----- rtl/pwlt_pkg.sv -----
// Shared types and constants of the piecewise-linear range table.
// Used by pwlt_muldiv and piecewise_linear_table_interp; depends on nothing else.
`default_nettype none

package pwlt_pkg;

    localparam int VALUE_W    = 32;
    localparam int COLS       = 4;
    localparam int INDEX_W    = 6;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;
    localparam int SEL_W      = 3;
    localparam int COUNT_W    = 7;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    localparam logic [1:0] ST_INSIDE = 2'd0;
    localparam logic [1:0] ST_BELOW  = 2'd1;
    localparam logic [1:0] ST_ABOVE  = 2'd2;
    localparam logic [1:0] ST_SAT    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_MODEL_SELECT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KNOT_COUNT   = 1'd1;

    typedef struct packed {
        logic               func;
        logic [INDEX_W-1:0] knot_index;
        logic [VALUE_W-1:0] knot_energy;
        logic [VALUE_W-1:0] range_model_one;
        logic [VALUE_W-1:0] range_model_two;
        logic [VALUE_W-1:0] range_model_three;
        logic [VALUE_W-1:0] range_model_four;
        logic [VALUE_W-1:0] query_energy;
    } req_t;

    typedef struct packed {
        logic [VALUE_W-1:0] range_value;
        logic [1:0]         lookup_status;
    } rsp_t;

    typedef struct packed {
        logic               start;
        logic [VALUE_W-1:0] a;
        logic [VALUE_W-1:0] b;
        logic [VALUE_W-1:0] d;
    } md_req_t;

    typedef struct packed {
        logic               done;
        logic [VALUE_W-1:0] quotient;
    } md_rsp_t;

endpackage

`default_nettype wire

// ----- rtl/pwlt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module pwlt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/pwlt_muldiv.sv -----
// Sequential floor(a*b/d) unit: one multiply, then one restoring divide step per cycle.
// Depends on pwlt_pkg. The quotient must fit VALUE_W bits (high product half below d).
`default_nettype none

module pwlt_muldiv (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire pwlt_pkg::md_req_t req,
    output pwlt_pkg::md_rsp_t      rsp
);

    import pwlt_pkg::*;

    localparam logic [1:0] MD_IDLE = 2'd0;
    localparam logic [1:0] MD_MUL  = 2'd1;
    localparam logic [1:0] MD_DIV  = 2'd2;
    localparam logic [1:0] MD_FIN  = 2'd3;

    localparam int CNT_W = $clog2(VALUE_W);

    logic [1:0]           state_reg, state_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [VALUE_W-1:0]   a_reg, b_reg, d_reg;
    logic [VALUE_W-1:0]   rem_reg, rem_next;
    logic [VALUE_W-1:0]   sh_reg, sh_next;
    logic [2*VALUE_W-1:0] prod;
    logic [VALUE_W:0]     trial;
    logic                 ge;

    assign prod  = a_reg * b_reg;
    assign trial = {rem_reg, sh_reg[VALUE_W-1]};
    assign ge    = trial >= {1'b0, d_reg};

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        sh_next    = sh_reg;
        unique case (state_reg)
            MD_IDLE:
            begin
                if (req.start)
                begin
                    state_next = MD_MUL;
                end
            end
            MD_MUL:
            begin
                rem_next   = prod[2*VALUE_W-1:VALUE_W];
                sh_next    = prod[VALUE_W-1:0];
                cnt_next   = '0;
                state_next = MD_DIV;
            end
            MD_DIV:
            begin
                rem_next = ge ? VALUE_W'(trial - {1'b0, d_reg}) : trial[VALUE_W-1:0];
                sh_next  = {sh_reg[VALUE_W-2:0], ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(VALUE_W - 1))
                begin
                    state_next = MD_FIN;
                end
            end
            MD_FIN:
            begin
                state_next = MD_IDLE;
            end
            default:
            begin
                state_next = MD_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MD_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == MD_IDLE && req.start)
        begin
            a_reg <= req.a;
            b_reg <= req.b;
            d_reg <= req.d;
        end
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
    end

    assign rsp.done     = state_reg == MD_FIN;
    assign rsp.quotient = sh_reg;

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> state_reg == MD_IDLE)
        else $error("muldiv started while busy");
    a_done_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |-> $past(state_reg) == MD_DIV)
        else $error("muldiv done without divide steps");
    a_div_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == MD_DIV |-> rem_reg < d_reg)
        else $error("muldiv remainder not below divisor");
`endif

endmodule

`default_nettype wire

// ----- rtl/piecewise_linear_table_interp.sv -----
// Top level of the piecewise-linear range table: knot memories, search sequencer, output register.
// Depends on pwlt_pkg, pwlt_ram and pwlt_muldiv.
//
//   channel   signals                        beat
//   req       req_valid, req_stall, req      load of one knot row or one query
//   rsp       rsp_valid, rsp_stall, rsp      one result per query
//   cfg       cfg_we, cfg_index, cfg_data    register write
//
// A load does not raise req_stall. A query's duration grows with its interval n and is
// set by the linear knot search (one energy read per cycle) and the 32-step divide unit.
// Knots are searched one at a time.
// Reset clears control state only; the knot memories are undefined until written.
// req_stall is high while a query is in progress or its result cannot yet be registered.
`default_nettype none

module piecewise_linear_table_interp #(
    parameter int MAX_KNOTS = 64
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                req_valid,
    output logic                                     req_stall,
    input  wire pwlt_pkg::req_t                      req,
    output logic                                     rsp_valid,
    input  wire logic                                rsp_stall,
    output pwlt_pkg::rsp_t                           rsp,
    input  wire logic                                cfg_we,
    input  wire logic [pwlt_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [pwlt_pkg::CFG_DATA_W-1:0]     cfg_data
);

    import pwlt_pkg::*;

    localparam int AW  = $clog2(MAX_KNOTS);
    localparam int RW  = COLS * VALUE_W;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHK0  = 4'd1;
    localparam logic [3:0] S_SCAN  = 4'd2;
    localparam logic [3:0] S_RB    = 4'd3;
    localparam logic [3:0] S_RC    = 4'd4;
    localparam logic [3:0] S_DIV   = 4'd5;
    localparam logic [3:0] S_RLAST = 4'd6;
    localparam logic [3:0] S_DONE  = 4'd7;

    logic [3:0]         state_reg, state_next;
    logic [SEL_W-1:0]   model_select_reg;
    logic [COUNT_W-1:0] knot_count_reg;
    logic [1:0]         col_reg, col_next;
    logic [AW-1:0]      last_reg, last_next;
    logic [AW-1:0]      d_reg, d_next;
    logic [VALUE_W-1:0] e_reg, e_next;
    logic [VALUE_W-1:0] prev_reg, prev_next;
    logic [VALUE_W-1:0] de_reg, de_next;
    logic [VALUE_W-1:0] dd_reg, dd_next;
    logic [VALUE_W-1:0] rk_reg, rk_next;
    logic               sub_reg, sub_next;
    logic [VALUE_W-1:0] res_reg, res_next;
    logic [1:0]         st_reg, st_next;
    logic               rsp_valid_reg, rsp_valid_next;
    rsp_t               rsp_reg, rsp_next;

    logic               req_fire;
    logic               load_we;
    logic [31:0]        load_idx_wide;
    logic [31:0]        n_wide;
    logic [1:0]         col_sel;
    logic [AW-1:0]      e_raddr, r_raddr;
    logic [VALUE_W-1:0] eq;
    logic [RW-1:0]      rq_row;
    logic [VALUE_W-1:0] rq;
    logic               hit;
    logic [VALUE_W:0]   sum;
    md_req_t            md_req;
    md_rsp_t            md_rsp;

    assign req_stall     = state_reg != S_IDLE;
    assign req_fire      = req_valid && !req_stall;
    assign load_idx_wide = 32'(req.knot_index);
    assign load_we       = req_fire && req.func == FUNC_LOAD
                           && load_idx_wide < 32'(MAX_KNOTS);

    always_comb
    begin
        if (model_select_reg < SEL_W'(1))
        begin
            col_sel = 2'd0;
        end
        else if (model_select_reg > SEL_W'(COLS))
        begin
            col_sel = 2'(COLS - 1);
        end
        else
        begin
            col_sel = 2'(model_select_reg - SEL_W'(1));
        end
        if (32'(knot_count_reg) < 32'd2)
        begin
            n_wide = 32'd2;
        end
        else if (32'(knot_count_reg) > 32'(MAX_KNOTS))
        begin
            n_wide = 32'(MAX_KNOTS);
        end
        else
        begin
            n_wide = 32'(knot_count_reg);
        end
    end

    pwlt_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (MAX_KNOTS)
    ) u_energy_ram (
        .clk   (clk),
        .we    (load_we),
        .waddr (load_idx_wide[AW-1:0]),
        .wdata (req.knot_energy),
        .raddr (e_raddr),
        .rdata (eq)
    );

    pwlt_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_KNOTS)
    ) u_range_ram (
        .clk   (clk),
        .we    (load_we),
        .waddr (load_idx_wide[AW-1:0]),
        .wdata ({req.range_model_four, req.range_model_three,
                 req.range_model_two, req.range_model_one}),
        .raddr (r_raddr),
        .rdata (rq_row)
    );

    pwlt_muldiv u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (md_req),
        .rsp   (md_rsp)
    );

    assign rq  = rq_row[col_reg*VALUE_W +: VALUE_W];
    assign hit = (prev_reg <= e_reg) && (e_reg < eq);
    assign sum = {1'b0, rk_reg} + {1'b0, md_rsp.quotient};

    always_comb
    begin
        state_next     = state_reg;
        col_next       = col_reg;
        last_next      = last_reg;
        d_next         = d_reg;
        e_next         = e_reg;
        prev_next      = prev_reg;
        de_next        = de_reg;
        dd_next        = dd_reg;
        rk_next        = rk_reg;
        sub_next       = sub_reg;
        res_next       = res_reg;
        st_next        = st_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        e_raddr        = '0;
        r_raddr        = '0;
        md_req.start   = 1'b0;
        md_req.a       = rq;
        md_req.b       = de_reg;
        md_req.d       = dd_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire && req.func == FUNC_QUERY)
                begin
                    e_next     = req.query_energy;
                    col_next   = col_sel;
                    last_next  = AW'(n_wide - 32'd1);
                    state_next = S_CHK0;
                end
            end
            S_CHK0:
            begin
                if (e_reg < eq)
                begin
                    md_req.start = 1'b1;
                    md_req.b     = e_reg;
                    md_req.d     = eq;
                    rk_next      = '0;
                    sub_next     = 1'b0;
                    st_next      = ST_BELOW;
                    state_next   = S_DIV;
                end
                else
                begin
                    prev_next  = eq;
                    d_next     = AW'(1);
                    e_raddr    = AW'(1);
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (hit)
                begin
                    de_next    = e_reg - prev_reg;
                    dd_next    = eq - prev_reg;
                    r_raddr    = d_reg - AW'(1);
                    st_next    = ST_INSIDE;
                    state_next = S_RB;
                end
                else if (d_reg == last_reg)
                begin
                    if (e_reg == eq)
                    begin
                        r_raddr    = last_reg;
                        state_next = S_RLAST;
                    end
                    else
                    begin
                        res_next   = '0;
                        st_next    = ST_ABOVE;
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    prev_next = eq;
                    d_next    = d_reg + AW'(1);
                    e_raddr   = d_reg + AW'(1);
                end
            end
            S_RB:
            begin
                rk_next    = rq;
                r_raddr    = d_reg;
                state_next = S_RC;
            end
            S_RC:
            begin
                md_req.start = 1'b1;
                sub_next     = rq < rk_reg;
                md_req.a     = (rq < rk_reg) ? rk_reg - rq : rq - rk_reg;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                if (md_rsp.done)
                begin
                    if (sub_reg)
                    begin
                        res_next = rk_reg - md_rsp.quotient;
                    end
                    else if (sum[VALUE_W])
                    begin
                        res_next = '1;
                        st_next  = ST_SAT;
                    end
                    else
                    begin
                        res_next = sum[VALUE_W-1:0];
                    end
                    state_next = S_DONE;
                end
            end
            S_RLAST:
            begin
                res_next   = rq;
                st_next    = ST_INSIDE;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next.range_value   = res_reg;
                    rsp_next.lookup_status = st_reg;
                    rsp_valid_next         = 1'b1;
                    state_next             = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            rsp_valid_reg    <= 1'b0;
            model_select_reg <= SEL_W'(1);
            knot_count_reg   <= COUNT_W'(2);
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_MODEL_SELECT: model_select_reg <= cfg_data[SEL_W-1:0];
                    CFG_KNOT_COUNT:   knot_count_reg   <= cfg_data[COUNT_W-1:0];
                    default:          ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg  <= col_next;
        last_reg <= last_next;
        d_reg    <= d_next;
        e_reg    <= e_next;
        prev_reg <= prev_next;
        de_reg   <= de_next;
        dd_reg   <= dd_next;
        rk_reg   <= rk_next;
        sub_reg  <= sub_next;
        res_reg  <= res_next;
        st_reg   <= st_next;
        rsp_reg  <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTHESIS
    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(state_reg) == S_DONE)
        else $error("result beat raised outside the done state");
    a_md_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        md_rsp.done |-> state_reg == S_DIV)
        else $error("divide result arrived outside the divide state");
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> d_reg <= last_reg && d_reg != '0)
        else $error("knot search index out of bounds");
    a_no_sat: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.lookup_status != ST_SAT)
        else $error("interpolated range overflowed");
`endif

endmodule

`default_nettype wire

// ----- test/piecewise_linear_table_interp_tb.sv -----
// Testbench for piecewise_linear_table_interp: loads knot rows, queries ranges and checks every
// result against an interpolation predictor held here. Depends on pwlt_pkg and the block's RTL.
module piecewise_linear_table_interp_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pwlt_pkg::*;

    localparam int TABLE_ROWS     = 64;
    localparam int SETTLE_CYCLES  = 120;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 3000;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  req_valid = 1'b0;
    logic                  req_stall;
    req_t                  req_beat  = '0;
    logic                  rsp_valid;
    logic                  rsp_stall = 1'b0;
    rsp_t                  rsp_beat;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    logic [VALUE_W-1:0] knot_energy_tbl [TABLE_ROWS];
    logic [VALUE_W-1:0] knot_range_tbl  [TABLE_ROWS][COLS];
    logic [SEL_W-1:0]   model_sel_reg  = 3'd1;
    logic [COUNT_W-1:0] knot_count_reg = 7'd2;
    rsp_t               expected_lookups [$];
    rsp_t               oldest_lookup;

    int load_count     = 0;
    int query_count    = 0;
    int result_count   = 0;
    int mismatch_count = 0;
    int quiet_cycles   = 0;
    int send_idle_pct  = 0;
    int stall_pct      = 0;
    int hold_request   = 0;
    int hold_left      = 0;

    piecewise_linear_table_interp uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req_beat),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp_beat),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic [63:0] scaled_quotient(input logic [VALUE_W-1:0] a,
                                                    input logic [VALUE_W-1:0] b,
                                                    input logic [VALUE_W-1:0] d);
        logic [63:0] product;
        if (d == '0)
            return '0;
        product = 64'(a) * 64'(b);
        return product / 64'(d);
    endfunction

    function automatic int rows_in_use();
        if (knot_count_reg < 2)
            return 2;
        if (knot_count_reg > TABLE_ROWS)
            return TABLE_ROWS;
        return int'(knot_count_reg);
    endfunction

    function automatic rsp_t lookup_range(input logic [VALUE_W-1:0] energy);
        rsp_t               result;
        int                 col;
        int                 rows;
        bit                 found;
        logic [63:0]        value;
        logic [VALUE_W-1:0] ek;
        logic [VALUE_W-1:0] ek1;
        logic [VALUE_W-1:0] rk;
        logic [VALUE_W-1:0] rk1;
        col = (model_sel_reg < 1) ? 0 : (model_sel_reg > 4) ? 3 : int'(model_sel_reg) - 1;
        rows = rows_in_use();
        value = '0;
        found = 1'b0;
        result.lookup_status = ST_ABOVE;
        if (energy < knot_energy_tbl[0])
        begin
            value = scaled_quotient(knot_range_tbl[0][col], energy, knot_energy_tbl[0]);
            result.lookup_status = ST_BELOW;
            found = 1'b1;
        end
        for (int k = 0; !found && k + 1 < rows; k++)
        begin
            ek  = knot_energy_tbl[k];
            ek1 = knot_energy_tbl[k + 1];
            if (energy >= ek && energy < ek1)
            begin
                rk  = knot_range_tbl[k][col];
                rk1 = knot_range_tbl[k + 1][col];
                if (rk1 >= rk)
                    value = 64'(rk) + scaled_quotient(rk1 - rk, energy - ek, ek1 - ek);
                else
                    value = 64'(rk) - scaled_quotient(rk - rk1, energy - ek, ek1 - ek);
                result.lookup_status = ST_INSIDE;
                found = 1'b1;
            end
        end
        if (!found && energy == knot_energy_tbl[rows - 1])
        begin
            value = 64'(knot_range_tbl[rows - 1][col]);
            result.lookup_status = ST_INSIDE;
        end
        if (value > 64'(32'hFFFF_FFFF))
        begin
            value = 64'(32'hFFFF_FFFF);
            result.lookup_status = ST_SAT;
        end
        result.range_value = value[VALUE_W-1:0];
        return result;
    endfunction

    function automatic logic [VALUE_W-1:0] random_range();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2: return $urandom_range(255);
            default: return $urandom;
        endcase
    endfunction

    function automatic req_t make_load(input int row, input logic [VALUE_W-1:0] energy,
                                       input logic [VALUE_W-1:0] r1, input logic [VALUE_W-1:0] r2,
                                       input logic [VALUE_W-1:0] r3, input logic [VALUE_W-1:0] r4);
        req_t item;
        item.func              = FUNC_LOAD;
        item.knot_index        = INDEX_W'(row);
        item.knot_energy       = energy;
        item.range_model_one   = r1;
        item.range_model_two   = r2;
        item.range_model_three = r3;
        item.range_model_four  = r4;
        item.query_energy      = $urandom;
        return item;
    endfunction

    function automatic req_t make_query(input logic [VALUE_W-1:0] energy);
        req_t item;
        item.func              = FUNC_QUERY;
        item.knot_index        = INDEX_W'($urandom);
        item.knot_energy       = $urandom;
        item.range_model_one   = $urandom;
        item.range_model_two   = $urandom;
        item.range_model_three = $urandom;
        item.range_model_four  = $urandom;
        item.query_energy      = energy;
        return item;
    endfunction

    function automatic req_t make_random_load(input int row);
        return make_load(row, $urandom, random_range(), random_range(), random_range(),
                         random_range());
    endfunction

    // Aims at the knots, the intervals between them and both ends of the table.
    function automatic logic [VALUE_W-1:0] pick_energy();
        int                 rows;
        int                 k;
        logic [VALUE_W-1:0] lo;
        logic [VALUE_W-1:0] hi;
        logic [VALUE_W-1:0] last;
        rows = rows_in_use();
        k    = $urandom_range(rows - 2);
        lo   = knot_energy_tbl[k];
        hi   = knot_energy_tbl[k + 1];
        last = knot_energy_tbl[rows - 1];
        case ($urandom_range(9))
            0: if (knot_energy_tbl[0] != '0)
                   return $urandom_range(knot_energy_tbl[0] - 1);
            1: return lo;
            2, 3, 4, 5: if (hi > lo)
                   return lo + ($urandom % (hi - lo));
            6: return last;
            7: if (last != '1)
                   return last + 1 + ($urandom % (~last));
            default: ;
        endcase
        return $urandom;
    endfunction

    task automatic send_item(input req_t item);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_beat  <= item;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        if (item.func == FUNC_LOAD)
        begin
            knot_energy_tbl[item.knot_index]   = item.knot_energy;
            knot_range_tbl[item.knot_index][0] = item.range_model_one;
            knot_range_tbl[item.knot_index][1] = item.range_model_two;
            knot_range_tbl[item.knot_index][2] = item.range_model_three;
            knot_range_tbl[item.knot_index][3] = item.range_model_four;
            load_count++;
        end
        else
        begin
            expected_lookups.insert(expected_lookups.size(), lookup_range(item.query_energy));
            query_count++;
        end
    endtask

    task automatic drain_traffic();
        req_valid <= 1'b0;
        while (expected_lookups.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input int value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= CFG_DATA_W'(value);
        @(posedge clk);
        if (index == CFG_MODEL_SELECT)
            model_sel_reg = SEL_W'(value);
        else
            knot_count_reg = COUNT_W'(value);
    endtask

    task automatic configure(input int sel, input int count);
        drain_traffic();
        write_reg(CFG_MODEL_SELECT, sel);
        write_reg(CFG_KNOT_COUNT, count);
        cfg_we <= 1'b0;
    endtask

    task automatic test_directed_lookup();
        logic [VALUE_W-1:0] probes [5];
        probes = '{32'h0000_0000, 32'h0000_FFFF, 32'h0001_8000, 32'h0005_0000, 32'hFFFF_FFFF};
        configure(1, 4);
        send_item(make_load(0, 32'h0001_0000, 32'h0000_8000, '1, '0, 32'h1234_5678));
        send_item(make_load(1, 32'h0002_0000, 32'h0001_0000, '0, '1, 32'h1234_5678));
        send_item(make_load(2, 32'h0008_0000, '1, 32'h8000_0000, 32'h0000_0001, '0));
        send_item(make_load(3, '1, '0, '1, 32'h7FFF_FFFF, '1));
        for (int sel = 1; sel <= 4; sel++)
        begin
            if (sel > 1)
                configure(sel, 4);
            foreach (probes[i])
                send_item(make_query(probes[i]));
        end
        configure(2, 3);
        send_item(make_query(32'h0001_0000));
        send_item(make_query(32'h0008_0000));
        send_item(make_query(32'h0009_0000));
    endtask

    task automatic test_first_knot_zero();
        configure(1, 2);
        send_item(make_load(0, '0, 32'h0000_0100, 32'h0000_0200, 32'h0000_0300, 32'h0000_0400));
        send_item(make_load(1, 32'h0001_0000, 32'h0003_0000, '0, '1, 32'h0000_0400));
        send_item(make_query(32'h0000_0000));
        send_item(make_query(32'h0000_8000));
        send_item(make_query(32'h0001_0000));
        send_item(make_query(32'h0001_0001));
    endtask

    task automatic test_unordered_table();
        configure(3, 3);
        send_item(make_load(0, 32'h0000_5000, '1, '1, 32'h0000_1000, '1));
        send_item(make_load(1, 32'h0000_3000, '0, '0, 32'h0000_2000, '0));
        send_item(make_load(2, 32'h0000_9000, '1, '0, 32'h0000_3000, '1));
        send_item(make_query(32'h0000_1000));
        send_item(make_query(32'h0000_4000));
        send_item(make_query(32'h0000_6000));
        send_item(make_query(32'h0000_9000));
        send_item(make_query(32'h0000_A000));
    endtask

    task automatic test_config_extremes();
        int settings [6][2];
        settings = '{'{0, 0}, '{5, 1}, '{7, 127}, '{4, 64}, '{1, 65}, '{6, 2}};
        for (int row = 0; row < TABLE_ROWS; row++)
            send_item(make_load(row, 32'(row) * 32'h0400_0000 + 32'h100, random_range(),
                                random_range(), random_range(), random_range()));
        foreach (settings[i])
        begin
            configure(settings[i][0], settings[i][1]);
            send_item(make_query(knot_energy_tbl[rows_in_use() - 1]));
            repeat (4) send_item(make_query(pick_energy()));
        end
    endtask

    // A well-formed table of random size and content, then mostly queries with some
    // stray row loads that may leave the table unordered.
    task automatic run_table_session(input int queries);
        int                 count_value;
        int                 sel_value;
        int                 rows;
        logic [VALUE_W-1:0] energy;
        logic [VALUE_W-1:0] step_max;
        case ($urandom_range(15))
            0: count_value = TABLE_ROWS;
            1: count_value = $urandom_range(1) ? $urandom_range(1) : $urandom_range(127, 65);
            default: count_value = $urandom_range(12, 2);
        endcase
        sel_value = ($urandom_range(3) == 0) ? $urandom_range(7) : $urandom_range(4, 1);
        configure(sel_value, count_value);
        rows = rows_in_use();
        case ($urandom_range(2))
            0:
            begin
                energy   = $urandom_range(1000, 1);
                step_max = 64;
            end
            1:
            begin
                energy   = $urandom_range(32'h0010_0000, 1);
                step_max = 32'h0001_0000;
            end
            default:
            begin
                energy   = $urandom_range(32'h8000_0000, 1);
                step_max = (32'hFFFF_FFFF - energy) / rows;
            end
        endcase
        if ($urandom_range(9) == 0)
            energy = '0;
        for (int row = 0; row < rows; row++)
        begin
            send_item(make_load(row, energy, random_range(), random_range(), random_range(),
                                random_range()));
            energy = energy + 1 + ($urandom % step_max);
        end
        repeat (queries)
        begin
            if ($urandom_range(14) == 0)
                send_item(make_random_load($urandom_range(rows - 1)));
            send_item(make_query(pick_energy()));
        end
    endtask

    task automatic run_random_phase(input int idle_pct, input int stall_in_pct, input int budget);
        int target;
        send_idle_pct = idle_pct;
        stall_pct     = stall_in_pct;
        target        = load_count + query_count + budget;
        while (load_count + query_count < target)
            run_table_session($urandom_range(40, 15));
    endtask

    task automatic test_random_no_idle();
        run_random_phase(0, 0, 300);
    endtask

    task automatic test_random_sender_idle();
        run_random_phase(85, 0, 300);
    endtask

    task automatic test_random_receiver_stall();
        run_random_phase(0, 85, 300);
    endtask

    task automatic test_random_both_idle();
        run_random_phase(31, 31, 300);
    endtask

    task automatic test_output_hold_off();
        drain_traffic();
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_request  = HOLD_CYCLES;
        repeat (16) send_item(make_query(pick_energy()));
    endtask

    always @(posedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
            hold_left--;
        rsp_stall <= (hold_left > 0) || ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                result_count++;
                if (expected_lookups.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: result beat with nothing expected: range_value=%h status=%0d",
                             $time, rsp_beat.range_value, rsp_beat.lookup_status);
                end
                else
                begin
                    oldest_lookup = expected_lookups.pop_front();
                    if (rsp_beat.range_value !== oldest_lookup.range_value)
                    begin
                        mismatch_count++;
                        $display("%0t: range_value expected %h actual %h", $time,
                                 oldest_lookup.range_value, rsp_beat.range_value);
                    end
                    if (rsp_beat.lookup_status !== oldest_lookup.lookup_status)
                    begin
                        mismatch_count++;
                        $display("%0t: lookup_status expected %0d actual %0d", $time,
                                 oldest_lookup.lookup_status, rsp_beat.lookup_status);
                    end
                end
            end
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || cfg_we)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no beat accepted for %0d cycles", $time, quiet_cycles);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_directed_lookup();
        test_first_knot_zero();
        test_unordered_table();
        test_config_extremes();
        test_random_no_idle();
        test_random_sender_idle();
        test_random_receiver_stall();
        test_random_both_idle();
        test_output_hold_off();
        drain_traffic();
        $display("Checked %0d results from %0d queries and %0d knot row loads.",
                 result_count, query_count, load_count);
        $display("Covered lookups inside, below and above the table, clamped settings, ",
                 "unordered tables, idle and stall mixes and a long output hold-off.");
        if (mismatch_count == 0 && expected_lookups.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
